FILE: sv/occupancy_grid_nearest_obstacle_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the occupancy grid nearest-obstacle block
// Shared concurrent assertion forms, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef OCCUPANCY_GRID_NEAREST_OBSTACLE_ASSERT_SVH
`define OCCUPANCY_GRID_NEAREST_OBSTACLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define OGNO_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define OGNO_ASSERT(label, prop, msg) `OGNO_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)
`else
`define OGNO_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define OGNO_ASSERT(label, prop, msg)
`endif
`endif

FILE: sv/ogno_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogno_pkg
// Shared widths and codes of the occupancy grid nearest-obstacle block.
// ----------------------------------------------------------------------------
package ogno_pkg;

    localparam int POS_W  = 20;   // Q12.8 world coordinate
    localparam int EXT_W  = 20;   // grid extent register
    localparam int KIND_W = 2;
    localparam int CELL_W = 4;
    localparam int DIFF_W = 21;   // signed point-to-corner offset
    localparam int TERM_W = 40;   // one squared offset
    localparam int SQ_W   = 42;   // sum of three squared offsets
    localparam int ROOT_W = SQ_W / 2;
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    localparam logic [1:0] REG_EXTENT_X = 2'd0;
    localparam logic [1:0] REG_EXTENT_Y = 2'd1;
    localparam logic [1:0] REG_EXTENT_Z = 2'd2;

    localparam logic [EXT_W-1:0] EXTENT_RESET = 20'd4096;

endpackage

FILE: sv/ogno_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogno_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ogno_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: sv/ogno_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogno_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ogno_div #(
    parameter int NUM_W = 29,
    parameter int DEN_W = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot,
    output logic [DEN_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_run;
    logic             r_done;
    logic [DEN_W:0]   partial;
    logic             q_bit;
    logic [DEN_W:0]   diff;

    always_comb begin
        partial = {r_rem, r_num[NUM_W-1]};
        diff    = partial - {1'b0, r_den};
        q_bit   = (partial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(NUM_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_run) begin
            r_num <= {r_num[NUM_W-2:0], q_bit};
            r_rem <= q_bit ? diff[DEN_W-1:0] : partial[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;
    assign o_rem  = r_rem;

endmodule

FILE: sv/ogno_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogno_isqrt
// Integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ogno_isqrt #(
    parameter int IN_W = 42
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [IN_W-1:0]     i_value,
    output logic                o_done,
    output logic [IN_W/2-1:0]   o_root
);

    localparam int OUT_W = IN_W / 2;
    localparam int REM_W = OUT_W + 3;
    localparam int CNT_W = $clog2(OUT_W + 1);

    logic [IN_W-1:0]  r_val;
    logic [REM_W-1:0] r_rem;
    logic [OUT_W-1:0] r_root;
    logic [CNT_W-1:0] r_cnt;
    logic             r_run;
    logic             r_done;
    logic [REM_W-1:0] trial;
    logic [REM_W-1:0] test;
    logic             take;

    always_comb begin
        trial = {r_rem[REM_W-3:0], r_val[IN_W-1:IN_W-2]};
        test  = {1'b0, r_root, 2'b01};
        take  = (trial >= test);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(OUT_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_run) begin
            r_val  <= {r_val[IN_W-3:0], 2'b00};
            r_rem  <= take ? (trial - test) : trial;
            r_root <= {r_root[OUT_W-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

FILE: sv/occupancy_grid_nearest_obstacle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_grid_nearest_obstacle
// 3D occupancy bitmap with a nearest-obstacle distance query.
// ----------------------------------------------------------------------------
// Channel    | Direction | Handshake                    | Payload
// -----------+-----------+------------------------------+---------------------------
// command    | in        | start & !busy                | i_kind, i_cell_*, i_pos_*,
//            |           |                              | i_search_limit
// result     | out       | o_done strobe, one cycle     | o_distance
// config     | in/out    | psel & penable & pwrite      | paddr, pwdata, prdata
//
// A cell write completes in the beat that accepts it and busy never rises.
// A clear item, and reset itself, sweep the map one cell per cycle, over all
// CELLS_X*CELLS_Y*CELLS_Z cells (4096 at the defaults) with busy high.
// A query takes 12 divisions (four per axis), then one cycle
// per scanned cell of the clipped cube (at most (2*MAX_RADIUS_CELLS+1)^3, set by
// the single map read port), a drain of the distance pipeline, a square
// root when an obstacle was seen, and face clamping on each axis in turn.
// The result strobe cannot be held off by the receiver.
// ----------------------------------------------------------------------------
`include "occupancy_grid_nearest_obstacle_assert.svh"

module occupancy_grid_nearest_obstacle #(
    parameter int CELLS_X          = 16,
    parameter int CELLS_Y          = 16,
    parameter int CELLS_Z          = 16,
    parameter int MAX_RADIUS_CELLS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [ogno_pkg::KIND_W-1:0]    i_kind,
    input  logic [ogno_pkg::CELL_W-1:0]    i_cell_x,
    input  logic [ogno_pkg::CELL_W-1:0]    i_cell_y,
    input  logic [ogno_pkg::CELL_W-1:0]    i_cell_z,
    input  logic                           i_cell_occupied,
    input  logic [ogno_pkg::POS_W-1:0]     i_pos_x,
    input  logic [ogno_pkg::POS_W-1:0]     i_pos_y,
    input  logic [ogno_pkg::POS_W-1:0]     i_pos_z,
    input  logic [ogno_pkg::POS_W-1:0]     i_search_limit,
    output logic                           o_done,
    output logic [ogno_pkg::POS_W-1:0]     o_distance,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ogno_pkg::APB_AW-1:0]    paddr,
    input  logic [ogno_pkg::APB_DW-1:0]    pwdata,
    output logic [ogno_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);

    import ogno_pkg::*;

    localparam int DEPTH     = CELLS_X * CELLS_Y * CELLS_Z;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CELLS_XY  = CELLS_X * CELLS_Y;
    localparam int CELLS_MAX = (CELLS_X > CELLS_Y) ?
                               ((CELLS_X > CELLS_Z) ? CELLS_X : CELLS_Z) :
                               ((CELLS_Y > CELLS_Z) ? CELLS_Y : CELLS_Z);
    localparam int CNT_W     = $clog2(CELLS_MAX + 1);
    localparam int IDX_W     = $clog2(CELLS_MAX);
    localparam int NUM_W     = POS_W + CNT_W;

    localparam logic [CNT_W-1:0] CELLS_A [3] = '{CNT_W'(CELLS_X), CNT_W'(CELLS_Y),
                                                 CNT_W'(CELLS_Z)};

    // One-hot sequencer states.
    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_CLEAR     = 9'b000000010,
        ST_DIV_GO    = 9'b000000100,
        ST_DIV_WAIT  = 9'b000001000,
        ST_SCAN      = 9'b000010000,
        ST_DRAIN     = 9'b000100000,
        ST_SQRT_GO   = 9'b001000000,
        ST_SQRT_WAIT = 9'b010000000,
        ST_CLAMP     = 9'b100000000
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [EXT_W-1:0] r_ext [3];
    logic [EXT_W-1:0] eff_ext [3];
    logic             cfg_wr;

    // Query operands and per-axis set-up results.
    logic [POS_W-1:0] r_pos [3];
    logic [POS_W-1:0] r_limit;
    logic [1:0]       r_axis;
    logic [1:0]       r_step;
    logic [NUM_W-1:0] r_c;
    logic [IDX_W-1:0] r_lo [3];
    logic [IDX_W-1:0] r_hi [3];
    logic [2:0]       r_empty;
    logic [EXT_W-1:0] r_eq [3];
    logic [CNT_W-1:0] r_er [3];
    logic [EXT_W-1:0] r_w0q [3];
    logic [CNT_W-1:0] r_w0r [3];

    // Scan position and the corner of the current cell on each axis.
    logic [IDX_W-1:0] r_idx [3];
    logic [EXT_W-1:0] r_wq [3];
    logic [CNT_W-1:0] r_wr [3];
    logic [EXT_W-1:0] step_q [3];
    logic [CNT_W-1:0] step_r [3];
    logic [CNT_W:0]   step_sum [3];

    // Distance pipeline.
    logic                     r_s1_vld;
    logic signed [DIFF_W-1:0] r_s1_d [3];
    logic signed [2*DIFF_W-1:0] prod [3];
    logic                     r_s2_vld;
    logic [TERM_W-1:0]        r_sq [3];
    logic                     r_s3_vld;
    logic [SQ_W-1:0]          r_s3_sum;
    logic [SQ_W-1:0]          r_min;
    logic                     r_have;

    // Result.
    logic [POS_W-1:0] r_best;
    logic [POS_W-1:0] r_dist;
    logic             r_done;
    logic [POS_W-1:0] clamp_pos;
    logic [POS_W-1:0] clamp_far;
    logic [POS_W-1:0] clamp_out;

    // Map memory.
    logic [ADDR_W-1:0] r_clr_addr;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic              ram_rdata;
    logic              accept;
    logic              wr_in_grid;
    logic [ADDR_W-1:0] wr_addr;

    // Shared divider and square root.
    logic             div_start;
    logic [NUM_W-1:0] div_num;
    logic [EXT_W-1:0] div_den;
    logic             div_done;
    logic [NUM_W-1:0] div_quot;
    logic [EXT_W-1:0] div_rem;
    logic             sqrt_start;
    logic             sqrt_done;
    logic [ROOT_W-1:0] sqrt_root;

    // Radius and index bounds of the axis just divided.
    logic [NUM_W-1:0] rad;
    logic [NUM_W:0]   lo_full;
    logic [NUM_W:0]   hi_full;
    logic [NUM_W:0]   cells_m1;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ADDR_W-1:0] x,
                                                   input logic [ADDR_W-1:0] y,
                                                   input logic [ADDR_W-1:0] z);
        return x + ADDR_W'(CELLS_X) * y + ADDR_W'(CELLS_XY) * z;
    endfunction

    // ------------------------------------------------------------------
    // Configuration port. A register holding zero behaves as one.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext[0] <= EXTENT_RESET;
            r_ext[1] <= EXTENT_RESET;
            r_ext[2] <= EXTENT_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_EXTENT_X: r_ext[0] <= pwdata[EXT_W-1:0];
                REG_EXTENT_Y: r_ext[1] <= pwdata[EXT_W-1:0];
                REG_EXTENT_Z: r_ext[2] <= pwdata[EXT_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_EXTENT_X: prdata = APB_DW'(r_ext[0]);
            REG_EXTENT_Y: prdata = APB_DW'(r_ext[1]);
            REG_EXTENT_Z: prdata = APB_DW'(r_ext[2]);
            default:      prdata = '0;
        endcase
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            eff_ext[a] = (r_ext[a] == '0) ? EXT_W'(1) : r_ext[a];
        end
    end

    // ------------------------------------------------------------------
    // Command acceptance and map port selection. Writes outside the
    // grid are dropped; during a sweep every cell is written with zero.
    // ------------------------------------------------------------------
    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    assign wr_in_grid = ((CNT_W + CELL_W)'(i_cell_x) < (CNT_W + CELL_W)'(CELLS_X)) &&
                        ((CNT_W + CELL_W)'(i_cell_y) < (CNT_W + CELL_W)'(CELLS_Y)) &&
                        ((CNT_W + CELL_W)'(i_cell_z) < (CNT_W + CELL_W)'(CELLS_Z));
    assign wr_addr = cell_addr(ADDR_W'(i_cell_x), ADDR_W'(i_cell_y), ADDR_W'(i_cell_z));

    always_comb begin
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = 1'b0;
        end else begin
            ram_we    = accept && (i_kind == KIND_WRITE) && wr_in_grid;
            ram_waddr = wr_addr;
            ram_wdata = i_cell_occupied;
        end
    end

    assign ram_raddr = cell_addr(ADDR_W'(r_idx[0]), ADDR_W'(r_idx[1]), ADDR_W'(r_idx[2]));

    ogno_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Divider operands. Per axis the steps are: point cell, cell radius,
    // extent per cell (quotient and remainder) and the first corner.
    // ------------------------------------------------------------------
    assign div_start = (r_state == ST_DIV_GO);

    always_comb begin
        case (r_step)
            2'd0: begin
                div_num = NUM_W'(r_pos[r_axis]) * NUM_W'(CELLS_A[r_axis]);
                div_den = eff_ext[r_axis];
            end
            2'd1: begin
                div_num = NUM_W'(r_limit) * NUM_W'(CELLS_A[r_axis]);
                div_den = eff_ext[r_axis];
            end
            2'd2: begin
                div_num = NUM_W'(eff_ext[r_axis]);
                div_den = EXT_W'(CELLS_A[r_axis]);
            end
            default: begin
                div_num = NUM_W'(r_lo[r_axis]) * NUM_W'(eff_ext[r_axis]);
                div_den = EXT_W'(CELLS_A[r_axis]);
            end
        endcase
    end

    ogno_div #(
        .NUM_W (NUM_W),
        .DEN_W (EXT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    // The scan range is clipped to the grid; a range that starts past the
    // last cell is empty and no cell is read at all.
    always_comb begin
        rad      = (div_quot > NUM_W'(MAX_RADIUS_CELLS)) ? NUM_W'(MAX_RADIUS_CELLS) : div_quot;
        lo_full  = (r_c >= rad) ? {1'b0, r_c - rad} : '0;
        hi_full  = {1'b0, r_c} + {1'b0, rad};
        cells_m1 = (NUM_W + 1)'(CELLS_A[r_axis]) - 1'b1;
    end

    // ------------------------------------------------------------------
    // Corner stepping: w(i+1) = w(i) + E div C, carrying the remainder,
    // so no division is needed inside the scan.
    // ------------------------------------------------------------------
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            step_sum[a] = {1'b0, r_wr[a]} + {1'b0, r_er[a]};
            if (step_sum[a] >= {1'b0, CELLS_A[a]}) begin
                step_r[a] = CNT_W'(step_sum[a] - {1'b0, CELLS_A[a]});
                step_q[a] = r_wq[a] + r_eq[a] + 1'b1;
            end else begin
                step_r[a] = step_sum[a][CNT_W-1:0];
                step_q[a] = r_wq[a] + r_eq[a];
            end
        end
    end

    // ------------------------------------------------------------------
    // Distance pipeline: offsets with the read issue, squares once the
    // cell's bit is back, then the sum, then the running minimum of the
    // squared distance. The root is monotonic, so one root at the end
    // gives the same answer as a root per cell.
    // ------------------------------------------------------------------
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            prod[a] = r_s1_d[a] * r_s1_d[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= (r_state == ST_SCAN);
            r_s2_vld <= r_s1_vld && ram_rdata;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_s1_d[a] <= $signed({1'b0, r_pos[a]}) - $signed({1'b0, r_wq[a]});
            r_sq[a]   <= prod[a][TERM_W-1:0];
        end
        r_s3_sum <= SQ_W'(r_sq[0]) + SQ_W'(r_sq[1]) + SQ_W'(r_sq[2]);
    end

    // ------------------------------------------------------------------
    // Final square root and face clamps.
    // ------------------------------------------------------------------
    assign sqrt_start = (r_state == ST_SQRT_GO);

    ogno_isqrt #(
        .IN_W (SQ_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_value (r_min),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    // The far face distance is zero when the point lies beyond the grid.
    always_comb begin
        clamp_pos = r_pos[r_axis];
        clamp_far = (clamp_pos > eff_ext[r_axis]) ? '0 : (eff_ext[r_axis] - clamp_pos);
        clamp_out = r_best;
        if (clamp_pos < clamp_out) begin
            clamp_out = clamp_pos;
        end
        if (clamp_far < clamp_out) begin
            clamp_out = clamp_far;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_done     <= 1'b0;
            r_dist     <= '0;
            r_axis     <= '0;
            r_step     <= '0;
            r_have     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_s3_vld && (!r_have || (r_s3_sum < r_min))) begin
                r_min  <= r_s3_sum;
                r_have <= 1'b1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept && (i_kind == KIND_CLEAR)) begin
                        r_clr_addr <= '0;
                        r_state    <= ST_CLEAR;
                    end else if (accept && (i_kind == KIND_QUERY)) begin
                        r_pos[0] <= i_pos_x;
                        r_pos[1] <= i_pos_y;
                        r_pos[2] <= i_pos_z;
                        r_limit  <= i_search_limit;
                        r_have   <= 1'b0;
                        r_axis   <= '0;
                        r_step   <= '0;
                        r_state  <= ST_DIV_GO;
                    end
                end
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_DIV_GO: begin
                    r_state <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        case (r_step)
                            2'd0: r_c <= div_quot;
                            2'd1: begin
                                r_lo[r_axis]    <= lo_full[IDX_W-1:0];
                                r_empty[r_axis] <= (lo_full > cells_m1);
                                r_hi[r_axis]    <= (hi_full >= cells_m1) ?
                                                   cells_m1[IDX_W-1:0] : hi_full[IDX_W-1:0];
                            end
                            2'd2: begin
                                r_eq[r_axis] <= div_quot[EXT_W-1:0];
                                r_er[r_axis] <= div_rem[CNT_W-1:0];
                            end
                            default: begin
                                r_w0q[r_axis] <= div_quot[EXT_W-1:0];
                                r_w0r[r_axis] <= div_rem[CNT_W-1:0];
                            end
                        endcase
                        r_step <= r_step + 1'b1;
                        if (r_step != 2'd3) begin
                            r_state <= ST_DIV_GO;
                        end else if (r_axis != 2'd2) begin
                            r_axis  <= r_axis + 1'b1;
                            r_state <= ST_DIV_GO;
                        end else if (r_empty != 3'b000) begin
                            // Nothing to scan: the limit stands until clamped.
                            r_best  <= r_limit;
                            r_axis  <= '0;
                            r_state <= ST_CLAMP;
                        end else begin
                            for (int a = 0; a < 2; a++) begin
                                r_idx[a] <= r_lo[a];
                                r_wq[a]  <= r_w0q[a];
                                r_wr[a]  <= r_w0r[a];
                            end
                            // The first corner of the last axis arrives in this very beat.
                            r_idx[2] <= r_lo[2];
                            r_wq[2]  <= div_quot[EXT_W-1:0];
                            r_wr[2]  <= div_rem[CNT_W-1:0];
                            r_state  <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    // z runs innermost, then y, then x.
                    if (r_idx[2] == r_hi[2]) begin
                        r_idx[2] <= r_lo[2];
                        r_wq[2]  <= r_w0q[2];
                        r_wr[2]  <= r_w0r[2];
                        if (r_idx[1] == r_hi[1]) begin
                            r_idx[1] <= r_lo[1];
                            r_wq[1]  <= r_w0q[1];
                            r_wr[1]  <= r_w0r[1];
                            if (r_idx[0] == r_hi[0]) begin
                                r_state <= ST_DRAIN;
                            end else begin
                                r_idx[0] <= r_idx[0] + 1'b1;
                                r_wq[0]  <= step_q[0];
                                r_wr[0]  <= step_r[0];
                            end
                        end else begin
                            r_idx[1] <= r_idx[1] + 1'b1;
                            r_wq[1]  <= step_q[1];
                            r_wr[1]  <= step_r[1];
                        end
                    end else begin
                        r_idx[2] <= r_idx[2] + 1'b1;
                        r_wq[2]  <= step_q[2];
                        r_wr[2]  <= step_r[2];
                    end
                end
                ST_DRAIN: begin
                    if (!r_s1_vld && !r_s2_vld && !r_s3_vld) begin
                        if (r_have) begin
                            r_state <= ST_SQRT_GO;
                        end else begin
                            r_best  <= r_limit;
                            r_axis  <= '0;
                            r_state <= ST_CLAMP;
                        end
                    end
                end
                ST_SQRT_GO: begin
                    r_state <= ST_SQRT_WAIT;
                end
                ST_SQRT_WAIT: begin
                    if (sqrt_done) begin
                        r_best  <= (sqrt_root < {1'b0, r_limit}) ?
                                   sqrt_root[POS_W-1:0] : r_limit;
                        r_axis  <= '0;
                        r_state <= ST_CLAMP;
                    end
                end
                ST_CLAMP: begin
                    r_best <= clamp_out;
                    if (r_axis == 2'd2) begin
                        r_dist  <= clamp_out;
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_axis <= r_axis + 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_done     = r_done;
    assign o_distance = r_dist;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `OGNO_ASSERT(a_done_after_clamp, o_done |-> $past(r_state == ST_CLAMP), "result without clamp")
    `OGNO_ASSERT(a_idle_pipe_empty, !busy |-> (!r_s1_vld && !r_s2_vld && !r_s3_vld), "pipe busy")
    `OGNO_ASSERT(a_no_write_in_scan, (r_state == ST_SCAN) |-> !ram_we, "map written during scan")
    `OGNO_ASSERT(a_root_needs_hit, (r_state == ST_SQRT_GO) |-> r_have, "root without obstacle")
    `OGNO_ASSERT(a_within_limit, o_done |-> (o_distance <= r_limit), "distance above limit")

endmodule
